// File: hw/rtl/efb_pkg.sv
// Package for the Ethernet frame builder: shared types, constants and the CRC step.
// No dependencies; every other file of the block but efb_checker imports it.
`timescale 1ns / 1ps

package efb_pkg;

	localparam int          HDR_BYTES       = 14;
	localparam int          FCS_BYTES       = 4;
	localparam int          CNT_W           = $clog2(HDR_BYTES + 1);
	localparam int          EFB_QUEUE_DEPTH = 4;
	localparam int          CFG_IDX_W       = 2;
	localparam int          CFG_DATA_W      = 48;
	localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [15:0] ETHER_TYPE_RST  = 16'h0800;

	localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ETHER_TYPE = 2'd2;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [15:0] ether_type;
	} cfg_t;

	// one queued input item, tagged by the front end
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       start;
	} entry_t;

	// reflected CRC-32 over one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/efb_front.sv
// Front end: accepts input items and tags the first byte of each frame.
// Depends on efb_pkg.
`timescale 1ns / 1ps

module efb_front
	import efb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       queue_full,
	input  logic [7:0] payload_byte,
	input  logic       frame_last,
	output logic       in_stall,
	output logic       push,
	output entry_t     push_entry
);

	logic in_frame_q;

	assign in_stall         = queue_full;
	assign push             = in_valid & ~queue_full;
	assign push_entry.data  = payload_byte;
	assign push_entry.last  = frame_last;
	assign push_entry.start = ~in_frame_q;

	// track frame boundaries as items are accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= ~frame_last;
		end
	end

endmodule

// File: hw/rtl/efb_queue.sv
// Short item queue between the front end and the byte sequencer.
// Depends on efb_pkg for the entry type.
`timescale 1ns / 1ps

module efb_queue
	import efb_pkg::*;
#(
	parameter int DEPTH = EFB_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CNT_W_Q'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/efb_back.sv
// Back end: byte sequencer that emits header, payload and FCS bytes and runs the CRC.
// Depends on efb_pkg; reads queued items from efb_queue.
`timescale 1ns / 1ps

module efb_back
	import efb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       head_valid,
	input  entry_t     head,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_end
);

	localparam logic [1:0] PH_NEW = 2'd0;
	localparam logic [1:0] PH_HDR = 2'd1;
	localparam logic [1:0] PH_FCS = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;
	logic             run_end_q;

	logic             adv;
	logic             emit;
	logic             take;
	logic             crc_upd;
	logic             crc_clr;
	logic [7:0]       byte_d;
	logic             fend_d;
	logic             rend_d;
	logic [31:0]      fcs;

	function automatic logic [7:0] hdr_byte(input cfg_t c, input logic [CNT_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			0:       b = c.dest_mac[47:40];
			1:       b = c.dest_mac[39:32];
			2:       b = c.dest_mac[31:24];
			3:       b = c.dest_mac[23:16];
			4:       b = c.dest_mac[15:8];
			5:       b = c.dest_mac[7:0];
			6:       b = c.src_mac[47:40];
			7:       b = c.src_mac[39:32];
			8:       b = c.src_mac[31:24];
			9:       b = c.src_mac[23:16];
			10:      b = c.src_mac[15:8];
			11:      b = c.src_mac[7:0];
			12:      b = c.ether_type[15:8];
			default: b = c.ether_type[7:0];
		endcase
		return b;
	endfunction

	assign adv = ~out_valid_q | ~out_stall;
	assign fcs = ~crc_q;
	assign pop = adv & take;

	always_comb begin
		emit    = 1'b0;
		take    = 1'b0;
		crc_upd = 1'b0;
		crc_clr = 1'b0;
		byte_d  = head.data;
		fend_d  = 1'b0;
		rend_d  = 1'b0;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		case (phase_q)
			PH_NEW: begin
				if (head_valid) begin
					emit    = 1'b1;
					crc_upd = 1'b1;
					if (head.start) begin
						byte_d  = hdr_byte(cfg, '0);
						phase_d = PH_HDR;
						cnt_d   = CNT_W'(1);
					end else begin
						take   = 1'b1;
						rend_d = ~head.last;
						if (head.last) begin
							phase_d = PH_FCS;
							cnt_d   = '0;
						end
					end
				end
			end
			PH_HDR: begin
				if (cnt_q == CNT_W'(HDR_BYTES)) begin
					// header done: the payload byte of the same item follows
					if (head_valid) begin
						emit    = 1'b1;
						crc_upd = 1'b1;
						take    = 1'b1;
						rend_d  = ~head.last;
						cnt_d   = '0;
						phase_d = head.last ? PH_FCS : PH_NEW;
					end
				end else begin
					emit    = 1'b1;
					crc_upd = 1'b1;
					byte_d  = hdr_byte(cfg, cnt_q);
					cnt_d   = cnt_q + 1'b1;
				end
			end
			PH_FCS: begin
				emit   = 1'b1;
				byte_d = fcs[8*cnt_q[1:0] +: 8];
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FCS_BYTES - 1)) begin
					fend_d  = 1'b1;
					rend_d  = 1'b1;
					crc_clr = 1'b1;
					phase_d = PH_NEW;
					cnt_d   = '0;
				end
			end
			default: begin
				phase_d = PH_NEW;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NEW;
			cnt_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			if (crc_clr)      crc_q <= CRC_INIT;
			else if (crc_upd) crc_q <= crc_byte(crc_q, byte_d);
		end
	end

	// hold the output byte while stalled
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_byte_q  <= byte_d;
			frame_end_q <= fend_d;
			run_end_q   <= rend_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_end   = run_end_q;

endmodule

// File: hw/rtl/ethernet_frame_builder_crc32.sv
// Top level of the Ethernet II frame builder with CRC-32 FCS; holds the configuration registers.
// Depends on efb_pkg, efb_front, efb_queue and efb_back.
//
//   channel  signals                                      direction
//   in       in_valid, in_stall, payload_byte, frame_last  payload into the block
//   out      out_valid, out_stall, out_byte, frame_end,    frame bytes out of the block
//            run_end
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data     register writes, ready always high
//
// The back-end sequencer emits one frame byte per cycle from its output register while items
// are queued and out_stall is low: the first byte of a frame is preceded by the 14 header bytes,
// the last is followed by the 4 FCS bytes. Input is stalled only when the four-entry queue is full.
// Reset is asynchronous, active low; no clearing pass is needed after it.
// An out stall holds the output byte and freezes the sequencer; the queue still fills.
`timescale 1ns / 1ps

module ethernet_frame_builder_crc32
	import efb_pkg::*;
#(
	parameter int QUEUE_DEPTH = EFB_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            payload_byte,
	input  logic                  frame_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  frame_end,
	output logic                  run_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	logic   queue_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   head_valid;
	entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_mac   <= '0;
			cfg_q.src_mac    <= '0;
			cfg_q.ether_type <= ETHER_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEST_MAC:   cfg_q.dest_mac   <= cfg_data;
				CFG_SRC_MAC:    cfg_q.src_mac    <= cfg_data;
				CFG_ETHER_TYPE: cfg_q.ether_type <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	efb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.queue_full   (queue_full),
		.payload_byte (payload_byte),
		.frame_last   (frame_last),
		.in_stall     (in_stall),
		.push         (push),
		.push_entry   (push_entry)
	);

	efb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	efb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.run_end    (run_end)
	);

endmodule

// File: hw/rtl/efb_checker.sv
// Port-level checks for the frame builder output, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module efb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       run_end
);

	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(frame_end) && $stable(run_end))
		else $error("output item changed while stalled");

	// the last FCS byte always closes the run of its input item
	a_fend_rend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_end)
		else $error("frame end without run end");

	// a frame is at least header plus one byte plus FCS long
	a_no_back_fend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_end |=> !(out_valid && frame_end))
		else $error("two frame ends in a row");

endmodule

bind ethernet_frame_builder_crc32 efb_checker u_efb_checker (.*);
